@@ src/lspv_pkg.sv @@
package lspv_pkg;

    // Fixed field widths
    localparam int SMP_W  = 16;
    localparam int MIX_W  = 24;
    localparam int STEP_W = 24;
    localparam int GAIN_W = 16;
    localparam int ADDR_W = 16;
    localparam int FRAC_W = 16;
    localparam int IDX_W  = 18;
    localparam int POS_W  = IDX_W + FRAC_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // Default sizes for the top level parameters
    localparam int SAMPLE_DEPTH_DEF = 65536;
    localparam int HOLD_SPAN_DEF    = 24;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // Input op codes
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_START = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_END   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_MODE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_RATE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_MODE  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_BOOST_MODE = 3'd6;

    // Boost clip value, 0.125 in Q1.15
    localparam logic signed [SMP_W-1:0] BOOST_CLIP = 16'sd4096;

    typedef enum logic [1:0] {
        LOOP_STOP     = 2'd0,
        LOOP_FORWARD  = 2'd1,
        LOOP_BACKWARD = 2'd2,
        LOOP_BOUNCE   = 2'd3
    } t_loop_mode;

    typedef enum logic [1:0] {
        KIND_WRITE = 2'd0,
        KIND_START = 2'd1,
        KIND_TICK  = 2'd2
    } t_kind;

    typedef enum logic [3:0] {
        BS_IDLE,
        BS_EXEC,
        BS_HOLD,
        BS_WRAPQ,
        BS_WRAPR,
        BS_READ,
        BS_DATA,
        BS_GAIN,
        BS_MIX,
        BS_DONE
    } t_bstate;

    typedef struct packed {
        logic [15:0]       loop_start;
        logic [15:0]       loop_end;
        t_loop_mode        loop_mode;
        logic [STEP_W-1:0] step_rate;
        logic [GAIN_W-1:0] level;
        logic              hold_mode;
        logic              boost_mode;
    } t_cfg;

    typedef struct packed {
        t_kind                    kind;
        logic [ADDR_W-1:0]        address;
        logic signed [SMP_W-1:0]  sample_left;
        logic signed [SMP_W-1:0]  sample_right;
        logic [GAIN_W-1:0]        envelope_gain;
        logic                     envelope_active;
        logic signed [MIX_W-1:0]  mix_left;
        logic signed [MIX_W-1:0]  mix_right;
    } t_item;

endpackage

@@ src/looping_sample_playback_voice_top.sv @@
// Results: every tick produces one result, whether the voice plays or is idle;
// writes and starts produce no result.
// Sequencing: the back sequencer takes one item at a time; a playing tick passes index reduction
// multiplies, sample store read, two gain multiplies and the mix, and waits while the output stalls.
// Reset: synchronous, active low; clears voice state, queue, handshakes and config to
// defaults. The sample store is not cleared and reads undefined until written.
module looping_sample_playback_voice_top import lspv_pkg::*; #(
    parameter int SAMPLE_DEPTH = SAMPLE_DEPTH_DEF,
    parameter int HOLD_SPAN    = HOLD_SPAN_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [1:0]              i_op,
    input  logic [ADDR_W-1:0]       i_address,
    input  logic signed [SMP_W-1:0] i_sample_left,
    input  logic signed [SMP_W-1:0] i_sample_right,
    input  logic [GAIN_W-1:0]       i_envelope_gain,
    input  logic                    i_envelope_active,
    input  logic signed [MIX_W-1:0] i_mix_left,
    input  logic signed [MIX_W-1:0] i_mix_right,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic signed [MIX_W-1:0] o_out_left,
    output logic signed [MIX_W-1:0] o_out_right,
    output logic                    o_voice_playing,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data
);

    t_cfg  r_cfg;
    logic  push;
    logic  q_full;
    logic  q_valid;
    logic  q_pop;
    t_item push_item;
    t_item head_item;

    // Configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.loop_start <= 16'd0;
            r_cfg.loop_end   <= 16'hFFFF;
            r_cfg.loop_mode  <= LOOP_STOP;
            r_cfg.step_rate  <= 24'h010000;
            r_cfg.level      <= 16'hFFFF;
            r_cfg.hold_mode  <= 1'b0;
            r_cfg.boost_mode <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_LOOP_START: r_cfg.loop_start <= i_cfg_data[15:0];
                CFG_LOOP_END:   r_cfg.loop_end   <= i_cfg_data[15:0];
                CFG_LOOP_MODE:  r_cfg.loop_mode  <= t_loop_mode'(i_cfg_data[1:0]);
                CFG_STEP_RATE:  r_cfg.step_rate  <= i_cfg_data[STEP_W-1:0];
                CFG_LEVEL:      r_cfg.level      <= i_cfg_data[GAIN_W-1:0];
                CFG_HOLD_MODE:  r_cfg.hold_mode  <= i_cfg_data[0];
                CFG_BOOST_MODE: r_cfg.boost_mode <= i_cfg_data[0];
                default:        r_cfg.hold_mode  <= r_cfg.hold_mode;
            endcase
        end
    end

    lspv_front #(
        .SAMPLE_DEPTH(SAMPLE_DEPTH)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_op             (i_op),
        .i_address        (i_address),
        .i_sample_left    (i_sample_left),
        .i_sample_right   (i_sample_right),
        .i_envelope_gain  (i_envelope_gain),
        .i_envelope_active(i_envelope_active),
        .i_mix_left       (i_mix_left),
        .i_mix_right      (i_mix_right),
        .i_q_full         (q_full),
        .o_push           (push),
        .o_item           (push_item)
    );

    lspv_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_item (push_item),
        .o_full (q_full),
        .o_valid(q_valid),
        .o_item (head_item),
        .i_pop  (q_pop)
    );

    lspv_back #(
        .SAMPLE_DEPTH(SAMPLE_DEPTH),
        .HOLD_SPAN   (HOLD_SPAN)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_q_valid      (q_valid),
        .i_q_item       (head_item),
        .o_q_pop        (q_pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_out_left     (o_out_left),
        .o_out_right    (o_out_right),
        .o_voice_playing(o_voice_playing)
    );

endmodule

@@ src/lspv_front.sv @@
module lspv_front import lspv_pkg::*; #(
    parameter int SAMPLE_DEPTH = SAMPLE_DEPTH_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [1:0]              i_op,
    input  logic [ADDR_W-1:0]       i_address,
    input  logic signed [SMP_W-1:0] i_sample_left,
    input  logic signed [SMP_W-1:0] i_sample_right,
    input  logic [GAIN_W-1:0]       i_envelope_gain,
    input  logic                    i_envelope_active,
    input  logic signed [MIX_W-1:0] i_mix_left,
    input  logic signed [MIX_W-1:0] i_mix_right,
    input  logic                    i_q_full,
    output logic                    o_push,
    output t_item                   o_item
);

    logic  r_valid;
    logic  n_valid;
    t_item r_item;
    t_item cls_item;
    logic  keep;
    logic  accept;
    logic  addr_ok;

    // Classify the op and drop what has no effect
    assign addr_ok = (32'(i_address) < 32'(SAMPLE_DEPTH));

    always_comb begin
        cls_item.address         = i_address;
        cls_item.sample_left     = i_sample_left;
        cls_item.sample_right    = i_sample_right;
        cls_item.envelope_gain   = i_envelope_gain;
        cls_item.envelope_active = i_envelope_active;
        cls_item.mix_left        = i_mix_left;
        cls_item.mix_right       = i_mix_right;
        cls_item.kind            = KIND_TICK;
        keep                     = 1'b0;
        case (i_op)
            OP_WRITE: begin
                cls_item.kind = KIND_WRITE;
                keep          = addr_ok;
            end
            OP_START: begin
                cls_item.kind = KIND_START;
                keep          = 1'b1;
            end
            OP_TICK: begin
                cls_item.kind = KIND_TICK;
                keep          = 1'b1;
            end
            default: keep = 1'b0;
        endcase
    end

    // Hold one item until the queue takes it
    assign o_stall = r_valid & i_q_full;
    assign accept  = i_valid & ~o_stall;
    assign o_push  = r_valid & ~i_q_full;
    assign o_item  = r_item;
    assign n_valid = (accept & keep) | (r_valid & ~o_push);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= cls_item;
        end
    end

endmodule

@@ src/lspv_queue.sv @@
module lspv_queue import lspv_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    output logic  o_valid,
    output t_item o_item,
    input  logic  i_pop
);

    t_item               r_slot [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr;
    logic [QUEUE_AW-1:0] r_rd;
    logic [QUEUE_AW:0]   r_count;

    assign o_full  = (r_count == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_slot[r_rd];

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= QUEUE_AW'(r_wr + 1'b1);
            end
            if (i_pop) begin
                r_rd <= QUEUE_AW'(r_rd + 1'b1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr] <= i_item;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full && !i_pop))
        else $error("queue push while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("queue pop while empty");
`endif

endmodule

@@ src/lspv_back.sv @@
module lspv_back import lspv_pkg::*; #(
    parameter int SAMPLE_DEPTH = SAMPLE_DEPTH_DEF,
    parameter int HOLD_SPAN    = HOLD_SPAN_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cfg                    i_cfg,
    input  logic                    i_q_valid,
    input  t_item                   i_q_item,
    output logic                    o_q_pop,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic signed [MIX_W-1:0] o_out_left,
    output logic signed [MIX_W-1:0] o_out_right,
    output logic                    o_voice_playing
);

    // Index reduction by reciprocal multiplication
    localparam int AW = $clog2(SAMPLE_DEPTH);
    localparam int MW = IDX_W + 1;
    localparam int PW = IDX_W + MW;
    localparam int HW = $clog2(HOLD_SPAN + 1);
    localparam int DW = $clog2(SAMPLE_DEPTH + 1);
    localparam int HS = IDX_W + $clog2(HOLD_SPAN);
    localparam int DS = IDX_W + $clog2(SAMPLE_DEPTH);
    localparam longint unsigned HM =
        ((64'd1 << HS) + 64'(HOLD_SPAN) - 64'd1) / 64'(HOLD_SPAN);
    localparam longint unsigned DM =
        ((64'd1 << DS) + 64'(SAMPLE_DEPTH) - 64'd1) / 64'(SAMPLE_DEPTH);

    localparam logic signed [MIX_W:0] SUM_MAX = 25'sd8388607;
    localparam logic signed [MIX_W:0] SUM_MIN = -25'sd8388608;

    t_bstate r_state;
    t_bstate n_state;
    t_item   r_item;

    // Voice state
    logic [POS_W-1:0] r_pos;
    logic             r_back;
    logic             r_active;

    // Datapath registers
    logic [IDX_W-1:0]        r_idx;
    logic [IDX_W-1:0]        r_qh;
    logic [IDX_W-1:0]        r_hidx;
    logic [IDX_W-1:0]        r_qd;
    logic [IDX_W-1:0]        r_ridx;
    logic [2*SMP_W-1:0]      r_rd;
    logic signed [32:0]      r_pl_l;
    logic signed [32:0]      r_pl_r;
    logic signed [49:0]      r_pe_l;
    logic signed [49:0]      r_pe_r;
    logic signed [MIX_W-1:0] r_res_l;
    logic signed [MIX_W-1:0] r_res_r;
    logic                    r_res_p;

    // Output register
    logic                    r_ov;
    logic signed [MIX_W-1:0] r_o_l;
    logic signed [MIX_W-1:0] r_o_r;
    logic                    r_o_p;

    logic [2*SMP_W-1:0] r_mem [SAMPLE_DEPTH];

    logic mem_we;
    logic mem_re;
    logic out_load;
    logic out_free;

    logic [IDX_W-1:0]    idx;
    logic [PW-1:0]       prod_h;
    logic [PW-1:0]       prod_d;
    logic [IDX_W+HW-1:0] hold_prod;
    logic [IDX_W+DW-1:0] wrap_prod;
    logic [31:0]         ridx_w;
    logic [31:0]         addr_w;
    logic [AW-1:0]       rd_addr;
    logic [AW-1:0]       wr_addr;

    logic signed [35:0] pos_ext;
    logic signed [35:0] step_ext;
    logic signed [35:0] np;
    logic signed [35:0] lo;
    logic signed [35:0] hi;
    logic signed [35:0] t_pos;
    logic               t_back;
    logic               t_active;
    logic               at_edge;

    logic signed [SMP_W-1:0] g_l;
    logic signed [SMP_W-1:0] g_r;
    logic signed [32:0]      lvl_ext;
    logic signed [49:0]      env_ext;

    function automatic logic signed [SMP_W-1:0] boost(input logic signed [SMP_W-1:0] s);
        logic signed [SMP_W+2:0] v;
        v = ($signed({{3{s[SMP_W-1]}}, s}) <<< 2) + $signed({{3{s[SMP_W-1]}}, s});
        if (v >= 19'sd32768) begin
            return BOOST_CLIP;
        end else if (v <= -19'sd32768) begin
            return -BOOST_CLIP;
        end else begin
            return v[SMP_W-1:0];
        end
    endfunction

    function automatic logic signed [MIX_W-1:0] mix_sat(input logic signed [49:0] p,
                                                        input logic signed [MIX_W-1:0] m);
        logic signed [MIX_W:0] sum;
        sum = 25'($signed(p[49:28])) + 25'(m);
        if (sum > SUM_MAX) begin
            return SUM_MAX[MIX_W-1:0];
        end else if (sum < SUM_MIN) begin
            return SUM_MIN[MIX_W-1:0];
        end else begin
            return sum[MIX_W-1:0];
        end
    endfunction

    // Index arithmetic
    assign idx       = r_pos[POS_W-1:FRAC_W];
    assign prod_h    = PW'(idx) * PW'(HM);
    assign hold_prod = (IDX_W+HW)'(r_qh) * (IDX_W+HW)'(HOLD_SPAN);
    assign prod_d    = PW'(r_hidx) * PW'(DM);
    assign wrap_prod = (IDX_W+DW)'(r_qd) * (IDX_W+DW)'(SAMPLE_DEPTH);
    assign ridx_w    = 32'(r_ridx);
    assign rd_addr   = ridx_w[AW-1:0];
    assign addr_w    = 32'(r_item.address);
    assign wr_addr   = addr_w[AW-1:0];

    // Position advance and edge handling
    assign pos_ext  = $signed({2'b00, r_pos});
    assign step_ext = $signed({12'd0, i_cfg.step_rate});
    assign np       = r_back ? (pos_ext - step_ext) : (pos_ext + step_ext);
    assign lo       = $signed({4'd0, i_cfg.loop_start, 16'd0});
    assign hi       = $signed({4'd0, i_cfg.loop_end, 16'd0});
    assign at_edge  = (np > hi) || (np < lo);

    always_comb begin
        t_pos    = np;
        t_back   = r_back;
        t_active = r_active;
        if (at_edge) begin
            case (i_cfg.loop_mode)
                LOOP_STOP: begin
                    t_active = 1'b0;
                    if (np < 36'sd0) begin
                        t_pos = '0;
                    end
                end
                LOOP_FORWARD:  t_pos = lo;
                LOOP_BACKWARD: t_pos = hi;
                LOOP_BOUNCE: begin
                    t_back = ~r_back;
                    if (np < lo) begin
                        t_pos = lo;
                    end
                    if (t_pos > hi) begin
                        t_pos = hi;
                    end
                end
                default: t_pos = np;
            endcase
        end
        if (!r_item.envelope_active) begin
            t_active = 1'b0;
        end
    end

    // Gain stages
    assign g_l     = i_cfg.boost_mode ? boost($signed(r_rd[2*SMP_W-1:SMP_W])) :
                                        $signed(r_rd[2*SMP_W-1:SMP_W]);
    assign g_r     = i_cfg.boost_mode ? boost($signed(r_rd[SMP_W-1:0])) :
                                        $signed(r_rd[SMP_W-1:0]);
    assign lvl_ext = $signed({17'd0, i_cfg.level});
    assign env_ext = $signed({34'd0, r_item.envelope_gain});

    assign out_free = ~r_ov | ~i_stall;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            BS_IDLE: begin
                if (i_q_valid) begin
                    n_state = BS_EXEC;
                end
            end
            BS_EXEC: begin
                case (r_item.kind)
                    KIND_TICK: n_state = r_active ? BS_HOLD : BS_DONE;
                    default:   n_state = BS_IDLE;
                endcase
            end
            BS_HOLD:  n_state = BS_WRAPQ;
            BS_WRAPQ: n_state = BS_WRAPR;
            BS_WRAPR: n_state = BS_READ;
            BS_READ:  n_state = BS_DATA;
            BS_DATA:  n_state = BS_GAIN;
            BS_GAIN:  n_state = BS_MIX;
            BS_MIX:   n_state = BS_DONE;
            BS_DONE: begin
                if (out_free) begin
                    n_state = BS_IDLE;
                end
            end
            default: n_state = BS_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        o_q_pop  = 1'b0;
        mem_we   = 1'b0;
        mem_re   = 1'b0;
        out_load = 1'b0;
        case (r_state)
            BS_IDLE: o_q_pop  = i_q_valid;
            BS_EXEC: mem_we   = (r_item.kind == KIND_WRITE);
            BS_READ: mem_re   = 1'b1;
            BS_DONE: out_load = out_free;
            default: o_q_pop  = 1'b0;
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= BS_IDLE;
            r_pos    <= '0;
            r_back   <= 1'b0;
            r_active <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == BS_EXEC) begin
                if (r_item.kind == KIND_START) begin
                    r_back   <= (i_cfg.loop_mode == LOOP_BACKWARD);
                    r_pos    <= (i_cfg.loop_mode == LOOP_BACKWARD) ?
                                {2'b00, i_cfg.loop_end, 16'd0} :
                                {2'b00, i_cfg.loop_start, 16'd0};
                    r_active <= 1'b1;
                end else if (r_item.kind == KIND_TICK && r_active) begin
                    r_pos    <= t_pos[POS_W-1:0];
                    r_back   <= t_back;
                    r_active <= t_active;
                end
            end
            if (out_load) begin
                r_ov <= 1'b1;
            end else if (!i_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_item <= i_q_item;
        end
        case (r_state)
            BS_EXEC: begin
                r_idx   <= idx;
                r_qh    <= IDX_W'(prod_h >> HS);
                r_res_p <= t_active & r_active;
                r_res_l <= r_item.mix_left;
                r_res_r <= r_item.mix_right;
            end
            BS_HOLD:  r_hidx <= i_cfg.hold_mode ? hold_prod[IDX_W-1:0] : r_idx;
            BS_WRAPQ: r_qd   <= IDX_W'(prod_d >> DS);
            BS_WRAPR: r_ridx <= r_hidx - wrap_prod[IDX_W-1:0];
            BS_DATA: begin
                r_pl_l <= 33'(g_l) * lvl_ext;
                r_pl_r <= 33'(g_r) * lvl_ext;
            end
            BS_GAIN: begin
                r_pe_l <= 50'(r_pl_l) * env_ext;
                r_pe_r <= 50'(r_pl_r) * env_ext;
            end
            BS_MIX: begin
                r_res_l <= mix_sat(r_pe_l, r_item.mix_left);
                r_res_r <= mix_sat(r_pe_r, r_item.mix_right);
            end
            default: r_ridx <= r_ridx;
        endcase
        if (out_load) begin
            r_o_l <= r_res_l;
            r_o_r <= r_res_r;
            r_o_p <= r_res_p;
        end
    end

    // Sample store
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wr_addr] <= {r_item.sample_left, r_item.sample_right};
        end
        if (mem_re) begin
            r_rd <= r_mem[rd_addr];
        end
    end

    assign o_valid         = r_ov;
    assign o_out_left      = r_o_l;
    assign o_out_right     = r_o_r;
    assign o_voice_playing = r_o_p;

`ifndef SYNTHESIS
    a_hold_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BS_WRAPQ && i_cfg.hold_mode) |->
        (r_hidx <= r_idx && 32'(r_idx - r_hidx) < 32'(HOLD_SPAN)))
        else $error("held index is not the multiple below the position");
    a_read_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BS_READ) |-> (ridx_w < 32'(SAMPLE_DEPTH)))
        else $error("read index outside the sample store");
    a_playing_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> (!o_voice_playing || r_active))
        else $error("result reports playing while the voice is stopped");
`endif

endmodule

@@ dv/lspv_checker.sv @@
`timescale 1ns / 1ps

module lspv_checker import lspv_pkg::*; #(
    parameter int SAMPLE_DEPTH = SAMPLE_DEPTH_DEF,
    parameter int HOLD_SPAN    = HOLD_SPAN_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    input  logic                    i_in_stall,
    input  logic [1:0]              i_op,
    input  logic [ADDR_W-1:0]       i_address,
    input  logic signed [SMP_W-1:0] i_sample_left,
    input  logic signed [SMP_W-1:0] i_sample_right,
    input  logic [GAIN_W-1:0]       i_envelope_gain,
    input  logic                    i_envelope_active,
    input  logic signed [MIX_W-1:0] i_mix_left,
    input  logic signed [MIX_W-1:0] i_mix_right,
    input  logic                    i_out_valid,
    input  logic                    i_out_stall,
    input  logic signed [MIX_W-1:0] i_out_left,
    input  logic signed [MIX_W-1:0] i_out_right,
    input  logic                    i_voice_playing,
    input  logic                    i_cfg_valid,
    input  logic                    i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data,
    output int unsigned             o_outstanding,
    output int unsigned             o_errors
);

    typedef struct packed {
        logic signed [MIX_W-1:0] left;
        logic signed [MIX_W-1:0] right;
        logic                    playing;
    } t_frame;

    localparam longint MIX_MAX = (longint'(1) <<< (MIX_W - 1)) - 1;
    localparam longint MIX_MIN = -(longint'(1) <<< (MIX_W - 1));

    logic [SMP_W-1:0] left_mem  [SAMPLE_DEPTH];
    logic [SMP_W-1:0] right_mem [SAMPLE_DEPTH];
    logic [POS_W-1:0] position;
    logic             reverse;
    logic             active;
    t_cfg             cfg;
    t_frame           pending_frames [$];
    t_frame           want;
    int unsigned      err_cnt = 0;

    // Boost, scale by level and envelope, add to the mix and saturate
    function automatic logic signed [MIX_W-1:0] channel_mix(
        input logic signed [SMP_W-1:0] raw,
        input logic signed [MIX_W-1:0] mix,
        input logic [GAIN_W-1:0]       env
    );
        longint s;
        longint sum;
        s = raw;
        if (cfg.boost_mode) begin
            s = s * 5;
            if (s >= 32768)
                s = BOOST_CLIP;
            else if (s <= -32768)
                s = -longint'(BOOST_CLIP);
        end
        // Q1.47 product down to Q5.19, floor rounding
        sum = ((s * longint'(cfg.level) * longint'(env)) >>> 28) + mix;
        if (sum > MIX_MAX)
            sum = MIX_MAX;
        if (sum < MIX_MIN)
            sum = MIX_MIN;
        return sum[MIX_W-1:0];
    endfunction

    // Render one tick and advance the play position
    function automatic t_frame render_tick(
        input logic [GAIN_W-1:0]       env,
        input logic                    env_on,
        input logic signed [MIX_W-1:0] mix_l,
        input logic signed [MIX_W-1:0] mix_r
    );
        t_frame      f;
        int unsigned idx;
        longint      nxt;
        longint      lo;
        longint      hi;
        f.left    = mix_l;
        f.right   = mix_r;
        f.playing = 1'b0;
        if (!active)
            return f;

        idx = position[POS_W-1:FRAC_W];
        if (cfg.hold_mode)
            idx = idx - idx % HOLD_SPAN;
        idx = idx % SAMPLE_DEPTH;
        f.left  = channel_mix(left_mem[idx], mix_l, env);
        f.right = channel_mix(right_mem[idx], mix_r, env);

        nxt = longint'(position);
        nxt = reverse ? nxt - longint'(cfg.step_rate) : nxt + longint'(cfg.step_rate);
        lo  = longint'(cfg.loop_start) <<< FRAC_W;
        hi  = longint'(cfg.loop_end) <<< FRAC_W;
        if (nxt > hi || nxt < lo) begin
            case (cfg.loop_mode)
                LOOP_STOP: begin
                    active = 1'b0;
                    if (nxt < 0)
                        nxt = 0;
                end
                LOOP_FORWARD: begin
                    nxt = lo;
                end
                LOOP_BACKWARD: begin
                    nxt = hi;
                end
                default: begin
                    reverse = !reverse;
                    if (nxt < lo)
                        nxt = lo;
                    if (nxt > hi)
                        nxt = hi;
                end
            endcase
        end
        position = nxt[POS_W-1:0];
        if (!env_on)
            active = 1'b0;
        f.playing = active;
        return f;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n !== 1'b1) begin
            cfg.loop_start = '0;
            cfg.loop_end   = '1;
            cfg.loop_mode  = LOOP_STOP;
            cfg.step_rate  = 24'h010000;
            cfg.level      = '1;
            cfg.hold_mode  = 1'b0;
            cfg.boost_mode = 1'b0;
            position       = '0;
            reverse        = 1'b0;
            active         = 1'b0;
            pending_frames.delete();
        end else begin
            // Track register writes
            if (i_cfg_valid === 1'b1 && i_cfg_ready === 1'b1) begin
                case (i_cfg_index)
                    CFG_LOOP_START: cfg.loop_start = i_cfg_data[15:0];
                    CFG_LOOP_END:   cfg.loop_end   = i_cfg_data[15:0];
                    CFG_LOOP_MODE:  cfg.loop_mode  = t_loop_mode'(i_cfg_data[1:0]);
                    CFG_STEP_RATE:  cfg.step_rate  = i_cfg_data[STEP_W-1:0];
                    CFG_LEVEL:      cfg.level      = i_cfg_data[GAIN_W-1:0];
                    CFG_HOLD_MODE:  cfg.hold_mode  = i_cfg_data[0];
                    CFG_BOOST_MODE: cfg.boost_mode = i_cfg_data[0];
                    default: ;
                endcase
            end

            // Apply each input transfer to the voice state
            if (i_in_valid === 1'b1 && i_in_stall === 1'b0) begin
                case (i_op)
                    OP_WRITE: begin
                        if (i_address < SAMPLE_DEPTH) begin
                            left_mem[i_address]  = i_sample_left;
                            right_mem[i_address] = i_sample_right;
                        end
                    end
                    OP_START: begin
                        reverse  = (cfg.loop_mode == LOOP_BACKWARD);
                        position = POS_W'(reverse ? cfg.loop_end : cfg.loop_start) << FRAC_W;
                        active   = 1'b1;
                    end
                    OP_TICK: begin
                        pending_frames.push_back(render_tick(i_envelope_gain,
                            i_envelope_active, i_mix_left, i_mix_right));
                    end
                    default: ;
                endcase
            end

            // Compare each output transfer with the oldest expected frame
            if (i_out_valid === 1'b1 && i_out_stall === 1'b0) begin
                if (pending_frames.size() == 0) begin
                    $error("unexpected result: out_left %0d out_right %0d voice_playing %0b",
                        i_out_left, i_out_right, i_voice_playing);
                    err_cnt++;
                end else begin
                    want = pending_frames.pop_front();
                    if (i_out_left !== want.left) begin
                        $error("out_left: expected %0d, actual %0d", want.left, i_out_left);
                        err_cnt++;
                    end
                    if (i_out_right !== want.right) begin
                        $error("out_right: expected %0d, actual %0d", want.right, i_out_right);
                        err_cnt++;
                    end
                    if (i_voice_playing !== want.playing) begin
                        $error("voice_playing: expected %0b, actual %0b",
                            want.playing, i_voice_playing);
                        err_cnt++;
                    end
                end
            end
        end
        o_outstanding <= pending_frames.size();
        o_errors      <= err_cnt;
    end

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import lspv_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 24;
    localparam int PHASES         = 16;
    localparam int PHASE_ITEMS    = 75;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic signed [MIX_W-1:0] MIX_TOP    = {1'b0, {(MIX_W - 1){1'b1}}};
    localparam logic signed [MIX_W-1:0] MIX_BOTTOM = {1'b1, {(MIX_W - 1){1'b0}}};

    logic                    i_clk             = 1'b0;
    logic                    i_rst_n           = 1'b0;
    logic                    i_valid           = 1'b0;
    logic                    o_stall;
    logic [1:0]              i_op              = OP_WRITE;
    logic [ADDR_W-1:0]       i_address         = '0;
    logic signed [SMP_W-1:0] i_sample_left     = '0;
    logic signed [SMP_W-1:0] i_sample_right    = '0;
    logic [GAIN_W-1:0]       i_envelope_gain   = '0;
    logic                    i_envelope_active = 1'b0;
    logic signed [MIX_W-1:0] i_mix_left        = '0;
    logic signed [MIX_W-1:0] i_mix_right       = '0;
    logic                    o_valid;
    logic                    i_stall           = 1'b0;
    logic signed [MIX_W-1:0] o_out_left;
    logic signed [MIX_W-1:0] o_out_right;
    logic                    o_voice_playing;
    logic                    i_cfg_valid       = 1'b0;
    logic                    o_cfg_ready;
    logic [CFG_IDX_W-1:0]    i_cfg_index       = CFG_LOOP_START;
    logic [CFG_DATA_W-1:0]   i_cfg_data        = '0;

    int unsigned outstanding;
    int unsigned errors;
    int          send_idle_pct = 0;
    int          stall_pct     = 0;
    int unsigned quiet_cycles  = 0;
    bit          written [SAMPLE_DEPTH_DEF];

    looping_sample_playback_voice_top uut (.*);

    lspv_checker u_voice_check (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_valid),
        .i_in_stall        (o_stall),
        .i_op              (i_op),
        .i_address         (i_address),
        .i_sample_left     (i_sample_left),
        .i_sample_right    (i_sample_right),
        .i_envelope_gain   (i_envelope_gain),
        .i_envelope_active (i_envelope_active),
        .i_mix_left        (i_mix_left),
        .i_mix_right       (i_mix_right),
        .i_out_valid       (o_valid),
        .i_out_stall       (i_stall),
        .i_out_left        (o_out_left),
        .i_out_right       (o_out_right),
        .i_voice_playing   (o_voice_playing),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .o_outstanding     (outstanding),
        .o_errors          (errors)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Stall the result channel at random
    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // End the run when no transfer happens for too long
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && o_stall === 1'b0) || (o_valid === 1'b1 && !i_stall)
                    || (i_cfg_valid && o_cfg_ready === 1'b1)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("tb: failure");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    function automatic logic signed [SMP_W-1:0] rand_sample();
        case ($urandom_range(0, 7))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return $urandom_range(0, 1) ? 16'sd6554 : 16'sd6553;
            3: return $urandom_range(0, 1) ? -16'sd6554 : -16'sd6553;
            default: return SMP_W'($urandom());
        endcase
    endfunction

    function automatic logic signed [MIX_W-1:0] rand_mix();
        case ($urandom_range(0, 7))
            0: return MIX_TOP;
            1: return MIX_BOTTOM;
            default: return MIX_W'($urandom());
        endcase
    endfunction

    function automatic logic [GAIN_W-1:0] rand_gain();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            default: return GAIN_W'($urandom());
        endcase
    endfunction

    // Present one item, with an optional idle gap, and hold it until the transfer
    task automatic send_item(
        input logic [1:0]              op,
        input logic [ADDR_W-1:0]       addr,
        input logic signed [SMP_W-1:0] left,
        input logic signed [SMP_W-1:0] right,
        input logic [GAIN_W-1:0]       gain,
        input logic                    gain_on,
        input logic signed [MIX_W-1:0] mix_l,
        input logic signed [MIX_W-1:0] mix_r
    );
        if ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        i_valid           <= 1'b1;
        i_op              <= op;
        i_address         <= addr;
        i_sample_left     <= left;
        i_sample_right    <= right;
        i_envelope_gain   <= gain;
        i_envelope_active <= gain_on;
        i_mix_left        <= mix_l;
        i_mix_right       <= mix_r;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        if (op == OP_WRITE)
            written[addr] = 1'b1;
    endtask

    task automatic send_random(input logic [1:0] op, input logic [ADDR_W-1:0] addr);
        send_item(op, addr, rand_sample(), rand_sample(), rand_gain(),
            $urandom_range(0, 9) != 0, rand_mix(), rand_mix());
    endtask

    // Write every store entry in the span that holds no data yet
    task automatic fill_span(input int first, input int last);
        for (int a = first; a <= last; a++)
            if (!written[a])
                send_random(OP_WRITE, ADDR_W'(a));
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
    endtask

    task automatic apply_cfg(input t_cfg c);
        cfg_write(CFG_LOOP_START, CFG_DATA_W'(c.loop_start));
        cfg_write(CFG_LOOP_END, CFG_DATA_W'(c.loop_end));
        cfg_write(CFG_LOOP_MODE, CFG_DATA_W'(c.loop_mode));
        cfg_write(CFG_STEP_RATE, c.step_rate);
        cfg_write(CFG_LEVEL, CFG_DATA_W'(c.level));
        cfg_write(CFG_HOLD_MODE, CFG_DATA_W'(c.hold_mode));
        cfg_write(CFG_BOOST_MODE, CFG_DATA_W'(c.boost_mode));
        i_cfg_valid <= 1'b0;
    endtask

    // Drop valid, wait for every expected result, then let the back end go idle
    task automatic settle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_phase(input int p);
        t_cfg              c;
        int                lo;
        int                hi;
        int                sel;
        int                r;
        int                done_items;
        logic [ADDR_W-1:0] addr;

        case (p % 4)
            0: begin send_idle_pct = 0;  stall_pct <= 0;  end
            1: begin send_idle_pct = 78; stall_pct <= 0;  end
            2: begin send_idle_pct = 0;  stall_pct <= 78; end
            default: begin send_idle_pct = 6; stall_pct <= 6; end
        endcase

        // Pick the playback region; the first phases take the corner shapes
        sel = (p < 4) ? p : $urandom_range(0, 9);
        case (sel)
            0: begin lo = 65535; hi = 0; end
            1: begin lo = 0; hi = $urandom_range(0, 40); end
            2: begin hi = 65535; lo = 65535 - $urandom_range(0, 40); end
            3: begin hi = $urandom_range(0, 65000); lo = hi + $urandom_range(1, 30); end
            default: begin
                lo = 1000 * $urandom_range(0, 65) + $urandom_range(0, 30);
                hi = lo + $urandom_range(0, 47);
            end
        endcase
        c.loop_start = 16'(lo);
        c.loop_end   = 16'(hi);
        c.loop_mode  = t_loop_mode'((p / 4 + p) % 4);
        case (p % 5)
            0: c.step_rate = '0;
            1: c.step_rate = '1;
            2: c.step_rate = 24'h010000;
            3: c.step_rate = STEP_W'($urandom_range(1, 24'h03FFFF));
            default: c.step_rate = STEP_W'($urandom());
        endcase
        case (p % 7)
            3: c.level = '0;
            4: c.level = '1;
            default: c.level = GAIN_W'($urandom());
        endcase
        c.hold_mode  = 1'($urandom_range(0, 1));
        c.boost_mode = 1'($urandom_range(0, 1));
        apply_cfg(c);

        // Load every entry a tick may read, the hold snap included
        if (lo <= hi) begin
            fill_span(lo - lo % HOLD_SPAN_DEF, hi);
        end else begin
            fill_span(lo - lo % HOLD_SPAN_DEF, lo);
            fill_span(hi - hi % HOLD_SPAN_DEF, hi);
        end
        send_random(OP_START, ADDR_W'($urandom()));

        done_items = 0;
        while (done_items < PHASE_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 3) begin
                send_random(OP_UNUSED, ADDR_W'($urandom()));
            end else begin
                done_items++;
                if (r < 65) begin
                    send_random(OP_TICK, ADDR_W'($urandom()));
                end else if (r < 82) begin
                    if ($urandom_range(0, 3) == 0)
                        addr = ADDR_W'($urandom());
                    else if (lo <= hi)
                        addr = ADDR_W'($urandom_range(lo - lo % HOLD_SPAN_DEF, hi));
                    else
                        addr = ADDR_W'($urandom_range(0, 1) ? lo : hi);
                    send_random(OP_WRITE, addr);
                end else begin
                    send_random(OP_START, ADDR_W'($urandom()));
                end
            end
        end
        settle();
    endtask

    initial begin
        logic signed [SMP_W-1:0] corner_left  [8];
        logic signed [SMP_W-1:0] corner_right [8];
        t_cfg                    boost_cfg;

        corner_left  = '{16'sh7FFF, 16'sh8000, 16'sd6553, 16'sd6554,
                         -16'sd6553, -16'sd6554, 16'sd0, -16'sd1};
        corner_right = '{16'sh8000, 16'sh7FFF, -16'sd6554, -16'sd6553,
                         16'sd6554, 16'sd6553, -16'sd1, 16'sd0};

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Corner samples, idle ticks, saturation both ways, zero gain, envelope end
        for (int k = 0; k < 8; k++)
            send_item(OP_WRITE, ADDR_W'(k), corner_left[k], corner_right[k], '1, 1'b1,
                '0, '0);
        send_item(OP_TICK, '1, '0, '0, '1, 1'b1, MIX_TOP, MIX_BOTTOM);
        send_item(OP_TICK, '0, '0, '0, '0, 1'b0, MIX_BOTTOM, MIX_TOP);
        send_item(OP_START, '0, '0, '0, '0, 1'b1, '0, '0);
        send_item(OP_TICK, '0, '0, '0, '1, 1'b1, MIX_TOP, MIX_TOP);
        send_item(OP_TICK, '0, '0, '0, '1, 1'b1, MIX_BOTTOM, MIX_BOTTOM);
        send_item(OP_TICK, '0, '0, '0, '0, 1'b1, '0, '0);
        send_item(OP_UNUSED, '1, '1, '1, '1, 1'b1, '1, '1);
        send_item(OP_TICK, '0, '0, '0, 16'd1234, 1'b0, '0, '0);
        send_item(OP_TICK, '0, '0, '0, '1, 1'b1, 24'sd12345, -24'sd12345);
        settle();

        // Boost clip thresholds, read in order through a short forward loop
        boost_cfg.loop_start = 16'd0;
        boost_cfg.loop_end   = 16'd7;
        boost_cfg.loop_mode  = LOOP_FORWARD;
        boost_cfg.step_rate  = 24'h010000;
        boost_cfg.level      = '1;
        boost_cfg.hold_mode  = 1'b0;
        boost_cfg.boost_mode = 1'b1;
        apply_cfg(boost_cfg);
        send_item(OP_START, '0, '0, '0, '0, 1'b1, '0, '0);
        repeat (8) send_item(OP_TICK, '0, '0, '0, '1, 1'b1, '0, '0);
        settle();

        for (int p = 0; p < PHASES; p++)
            run_phase(p);

        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
